// ===== hw/rtl/jhsf_pkg.sv =====
// ----------------------------------------------------------------------------
// jhsf_pkg: shared types and constants for the JPEG header size fit block
// Marker codes, parser phase encoding, register indexes and the records
// passed between the parser, the fit logic and the top level.
// ----------------------------------------------------------------------------
package jhsf_pkg;

	// Byte and marker codes
	localparam logic [7:0] MARKER_PREFIX = 8'hFF;
	localparam logic [7:0] MARKER_SOI    = 8'hD8;
	localparam logic [7:0] MARKER_SOF0   = 8'hC0;
	localparam logic [7:0] MARKER_SOF2   = 8'hC2;

	// Field widths
	localparam int unsigned DIM_W   = 16;
	localparam int unsigned PANEL_W = 12;
	localparam int unsigned SHIFT_W = 2;
	localparam int unsigned CFG_IDX_W = 1;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 1'b1;
	localparam logic [PANEL_W-1:0]   PANEL_WIDTH_RST  = 12'd540;
	localparam logic [PANEL_W-1:0]   PANEL_HEIGHT_RST = 12'd888;

	// Parser phases, one-hot
	typedef enum logic [13:0] {
		PH_IDLE    = 14'b00000000000001,
		PH_SOI2    = 14'b00000000000010,
		PH_HUNT    = 14'b00000000000100,
		PH_MARK    = 14'b00000000001000,
		PH_LENH    = 14'b00000000010000,
		PH_LENL    = 14'b00000000100000,
		PH_SKIP    = 14'b00000001000000,
		PH_PREC    = 14'b00000010000000,
		PH_HH      = 14'b00000100000000,
		PH_HL      = 14'b00001000000000,
		PH_WH      = 14'b00010000000000,
		PH_WL      = 14'b00100000000000,
		PH_SOFLENH = 14'b01000000000000,
		PH_SOFLENL = 14'b10000000000000
	} phase_t;

	// Parser outcome for one byte
	typedef struct packed {
		logic             emit;
		logic             found;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} event_t;

	// One finished result
	typedef struct packed {
		logic               found;
		logic [DIM_W-1:0]   image_width;
		logic [DIM_W-1:0]   image_height;
		logic [SHIFT_W-1:0] scale_shift;
		logic [PANEL_W-1:0] x_offset;
		logic [PANEL_W-1:0] y_offset;
	} result_t;

endpackage

// ===== hw/rtl/jhsf_parser.sv =====
// ----------------------------------------------------------------------------
// jhsf_parser: byte-wise JPEG marker parser
// Checks the start-of-image bytes, skips segments by length and captures
// the frame size at SOF0 or SOF2. Reports at most one event per byte.
// ----------------------------------------------------------------------------
module jhsf_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       data_byte,
	input  logic             start_of_file,
	input  logic             end_of_file,
	output jhsf_pkg::event_t ev
);
	import jhsf_pkg::*;

	phase_t           phase_q, phase_d;
	logic [7:0]       len_hi_q, len_hi_d;
	logic [DIM_W-1:0] skip_q, skip_d;
	logic [DIM_W-1:0] height_q, height_d;
	logic [7:0]       width_hi_q, width_hi_d;
	logic [DIM_W-1:0] seg_len;
	logic [DIM_W-1:0] skip_len;
	logic [DIM_W-1:0] skip_dec;
	logic             done;

	// Segment length arithmetic; lengths below 2 skip nothing
	assign seg_len  = {len_hi_q, data_byte};
	assign skip_len = (seg_len >= DIM_W'(2)) ? seg_len - DIM_W'(2) : '0;
	assign skip_dec = skip_q - DIM_W'(1);

	// Next phase and event
	always_comb begin
		phase_d    = phase_q;
		len_hi_d   = len_hi_q;
		skip_d     = skip_q;
		height_d   = height_q;
		width_hi_d = width_hi_q;
		ev         = '0;
		done       = 1'b0;
		if (start_of_file) begin
			skip_d = '0;
			if (data_byte != MARKER_PREFIX) begin
				phase_d = PH_IDLE;
				ev.emit = 1'b1;
				done    = 1'b1;
			end else begin
				phase_d = PH_SOI2;
			end
		end else begin
			case (phase_q)
				PH_SOI2: begin
					if (data_byte != MARKER_SOI) begin
						phase_d = PH_IDLE;
						ev.emit = 1'b1;
						done    = 1'b1;
					end else begin
						phase_d = PH_HUNT;
					end
				end
				PH_HUNT: begin
					if (data_byte == MARKER_PREFIX)
						phase_d = PH_MARK;
				end
				PH_MARK: begin
					// repeated FF is fill
					if (data_byte == MARKER_SOF0 || data_byte == MARKER_SOF2)
						phase_d = PH_SOFLENH;
					else if (data_byte != MARKER_PREFIX)
						phase_d = PH_LENH;
				end
				PH_LENH: begin
					len_hi_d = data_byte;
					phase_d  = PH_LENL;
				end
				PH_SOFLENH: begin
					len_hi_d = data_byte;
					phase_d  = PH_SOFLENL;
				end
				PH_LENL: begin
					skip_d  = skip_len;
					phase_d = (skip_len != '0) ? PH_SKIP : PH_HUNT;
				end
				PH_SOFLENL: begin
					phase_d = PH_PREC;
				end
				PH_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == '0)
						phase_d = PH_HUNT;
				end
				PH_PREC: begin
					phase_d = PH_HH;
				end
				PH_HH: begin
					height_d = {data_byte, 8'h00};
					phase_d  = PH_HL;
				end
				PH_HL: begin
					height_d = {height_q[15:8], data_byte};
					phase_d  = PH_WH;
				end
				PH_WH: begin
					width_hi_d = data_byte;
					phase_d    = PH_WL;
				end
				PH_WL: begin
					phase_d  = PH_IDLE;
					ev.emit  = 1'b1;
					ev.found = 1'b1;
					ev.width = {width_hi_q, data_byte};
					ev.height = height_q;
					done     = 1'b1;
				end
				default: begin
					// idle: byte ignored, end of file too
					phase_d = PH_IDLE;
					done    = 1'b1;
				end
			endcase
		end
		// end of file inside a file that has not finished
		if (!done && end_of_file && phase_d != PH_IDLE) begin
			phase_d = PH_IDLE;
			ev.emit = 1'b1;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (advance) begin
			phase_q <= phase_d;
		end
	end

	// Captured fields and counters
	always_ff @(posedge clk) begin
		if (advance) begin
			len_hi_q   <= len_hi_d;
			skip_q     <= skip_d;
			height_q   <= height_d;
			width_hi_q <= width_hi_d;
		end
	end

endmodule

// ===== hw/rtl/jhsf_fit.sv =====
// ----------------------------------------------------------------------------
// jhsf_fit: panel fit for a captured frame size
// Picks a power-of-two downscale against the panel and the centering
// offsets of the scaled image, clamped at zero.
// ----------------------------------------------------------------------------
module jhsf_fit (
	input  jhsf_pkg::event_t                   ev,
	input  logic [jhsf_pkg::PANEL_W-1:0]       panel_width,
	input  logic [jhsf_pkg::PANEL_W-1:0]       panel_height,
	output jhsf_pkg::result_t                  res
);
	import jhsf_pkg::*;

	logic [DIM_W-1:0]   pw1, pw2, pw4;
	logic [DIM_W-1:0]   ph1, ph2, ph4;
	logic [SHIFT_W-1:0] shift;
	logic [DIM_W-1:0]   sw, sh;

	// Panel multiples, 14 bits at most
	assign pw1 = DIM_W'(panel_width);
	assign pw2 = DIM_W'({panel_width, 1'b0});
	assign pw4 = DIM_W'({panel_width, 2'b00});
	assign ph1 = DIM_W'(panel_height);
	assign ph2 = DIM_W'({panel_height, 1'b0});
	assign ph4 = DIM_W'({panel_height, 2'b00});

	// Downscale choice
	always_comb begin
		if (ev.width > pw4 || ev.height > ph4)
			shift = 2'd3;
		else if (ev.width > pw2 || ev.height > ph2)
			shift = 2'd2;
		else if (ev.width > pw1 || ev.height > ph1)
			shift = 2'd1;
		else
			shift = 2'd0;
	end

	assign sw = ev.width >> shift;
	assign sh = ev.height >> shift;

	// Result; a missing header gives all zero
	always_comb begin
		res              = '0;
		res.found        = ev.found;
		res.image_width  = ev.width;
		res.image_height = ev.height;
		if (ev.found) begin
			res.scale_shift = shift;
			if (sw < pw1)
				res.x_offset = (panel_width - sw[PANEL_W-1:0]) >> 1;
			if (sh < ph1)
				res.y_offset = (panel_height - sh[PANEL_W-1:0]) >> 1;
		end
	end

endmodule

// ===== hw/rtl/jpeg_header_size_fit.sv =====
// ----------------------------------------------------------------------------
// jpeg_header_size_fit: JPEG frame size scanner with panel fit
// Finds the SOF0/SOF2 frame header of a JPEG byte stream and reports the
// image size, a downscale and centering offsets for the configured panel.
// ----------------------------------------------------------------------------
// The block takes one file byte per clock cycle, with no gaps of its own,
// while in_stall is low. Each byte is parsed in the cycle it is transferred;
// a byte that ends the scan (bad start bytes, end of file, or the last width
// byte) loads an event register; the fit logic between it and the result
// register computes the result that the result register presents. The two
// registers drain independently, so new bytes keep flowing while a result
// waits; input stall rises only when both registers are held by a stalled
// output. Panel registers may be written only while no scan is in progress.
module jpeg_header_size_fit (
	input  logic                            clk,
	input  logic                            arst_n,
	// byte channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            start_of_file,
	input  logic                            end_of_file,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            found,
	output logic [jhsf_pkg::DIM_W-1:0]      image_width,
	output logic [jhsf_pkg::DIM_W-1:0]      image_height,
	output logic [jhsf_pkg::SHIFT_W-1:0]    scale_shift,
	output logic [jhsf_pkg::PANEL_W-1:0]    x_offset,
	output logic [jhsf_pkg::PANEL_W-1:0]    y_offset,
	// configuration
	input  logic                            cfg_wr_en,
	input  logic [jhsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jhsf_pkg::PANEL_W-1:0]    cfg_data
);
	import jhsf_pkg::*;

	logic [PANEL_W-1:0] panel_width_q;
	logic [PANEL_W-1:0] panel_height_q;
	event_t             ev;
	event_t             ev_s1;
	logic               valid_s1;
	result_t            fit_res;
	result_t            res_q;
	logic               out_valid_q;
	logic               out_free;
	logic               s1_free;
	logic               in_fire;

	// Handshake
	assign out_free = !out_valid_q || !out_stall;
	assign s1_free  = !valid_s1 || out_free;
	assign in_stall = !s1_free;
	assign in_fire  = in_valid && s1_free;

	// Panel registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q  <= PANEL_WIDTH_RST;
			panel_height_q <= PANEL_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PANEL_WIDTH:  panel_width_q  <= cfg_data;
				CFG_PANEL_HEIGHT: panel_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Byte parser
	jhsf_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (in_fire),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.end_of_file   (end_of_file),
		.ev            (ev)
	);

	// Event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_fire && ev.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && ev.emit)
			ev_s1 <= ev;
	end

	// Panel fit
	jhsf_fit u_fit (
		.ev           (ev_s1),
		.panel_width  (panel_width_q),
		.panel_height (panel_height_q),
		.res          (fit_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1)
			res_q <= fit_res;
	end

	assign out_valid    = out_valid_q;
	assign found        = res_q.found;
	assign image_width  = res_q.image_width;
	assign image_height = res_q.image_height;
	assign scale_shift  = res_q.scale_shift;
	assign x_offset     = res_q.x_offset;
	assign y_offset     = res_q.y_offset;

	// Checks
	a_event_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && ev.emit |=> valid_s1)
		else $error("event lost between parser and event register");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ev_s1.found |-> ev_s1.width == '0 && ev_s1.height == '0)
		else $error("failed scan carries a frame size");

	a_fit_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.found |->
			res_q.scale_shift == '0 && res_q.x_offset == '0 && res_q.y_offset == '0)
		else $error("fit fields set without a frame header");

endmodule
